### rtl/core/packed_raw_pixel_unpacker_core_assert.svh
// Assertion macros used by the checker file of the pixel unpacker.
`ifndef PACKED_RAW_PIXEL_UNPACKER_CORE_ASSERT_SVH
`define PACKED_RAW_PIXEL_UNPACKER_CORE_ASSERT_SVH

// Checked at every clock edge outside reset.
`define PRPU_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("pixel unpacker check failed");

// Checked at every clock edge, reset included.
`define PRPU_ASSERT_RESET(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("pixel unpacker reset check failed");

`endif

### rtl/core/prpu_pkg.sv
`timescale 1ns / 1ps

package prpu_pkg;

  localparam int unsigned MAX_DIMENSION = 16384;
  localparam int unsigned ACC_W = 44;
  localparam int unsigned VBC_W = 6;
  localparam int unsigned DIM_W = 15;
  localparam int unsigned POS_W = 14;
  localparam int unsigned ADDR_W = 28;
  localparam int unsigned PIX_W = 16;
  localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;

  localparam logic [DIM_W-1:0] MAX_DIM_VAL = DIM_W'(MAX_DIMENSION);
  localparam logic [DIM_W-1:0] WIDTH_RESET = 15'd4096;
  localparam logic [DIM_W-1:0] HEIGHT_RESET = 15'd2160;
  localparam logic [DIM_W-1:0] STRIDE_RESET = 15'd4096;
  localparam logic [VBC_W-1:0] ACC_BITS = 6'd44;
  localparam logic [4:0] DEPTH_12 = 5'd12;
  localparam logic [4:0] DEPTH_13 = 5'd13;
  localparam logic [12:0] MASK_12 = 13'h0FFF;
  localparam logic [12:0] MASK_13 = 13'h1FFF;

  typedef enum logic [1:0] {
    REG_BIT_DEPTH    = 2'd0,
    REG_FRAME_WIDTH  = 2'd1,
    REG_FRAME_HEIGHT = 2'd2,
    REG_LINE_STRIDE  = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic             depth13;
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
    logic [DIM_W-1:0] stride;
  } cfg_t;

  typedef struct packed {
    logic [ACC_W-1:0] acc;
    logic [VBC_W-1:0] bits;
    logic [1:0]       pixels;
    logic             start;
  } entry_t;

  function automatic logic [DIM_W-1:0] sat_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > MAX_DIM_VAL) begin
      r = MAX_DIM_VAL;
    end
    return r;
  endfunction

  function automatic logic [4:0] pixel_bits(input logic depth13);
    return depth13 ? DEPTH_13 : DEPTH_12;
  endfunction

endpackage

### rtl/core/prpu_front.sv
`timescale 1ns / 1ps

module prpu_front (
  input  logic                  clk,
  input  logic                  rst,
  input  prpu_pkg::cfg_t        cfg,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [31:0]           data_word,
  input  logic [2:0]            byte_count,
  input  logic                  frame_start,
  input  logic                  full,
  output logic                  push,
  output prpu_pkg::entry_t      push_entry
);
  import prpu_pkg::*;

  logic [ACC_W-1:0] acc;
  logic [ACC_W-1:0] acc_base;
  logic [ACC_W-1:0] acc_next;
  logic [VBC_W-1:0] bits;
  logic [VBC_W-1:0] bits_base;
  logic [VBC_W-1:0] bits_after;
  logic [VBC_W-1:0] bits_next;
  logic [VBC_W:0]   bits_sum;
  logic [4:0]       d;
  logic [VBC_W-1:0] d1;
  logic [VBC_W-1:0] d2;
  logic [VBC_W-1:0] d3;
  logic [VBC_W-1:0] used;
  logic [1:0]       pixels;
  logic             accept;

  always_comb begin
    acc_base = frame_start ? '0 : acc;
    bits_base = frame_start ? '0 : bits;
    case (byte_count)
      3'd0: begin
        acc_next = acc_base;
        bits_sum = {1'b0, bits_base};
      end
      3'd1: begin
        acc_next = {acc_base[35:0], data_word[7:0]};
        bits_sum = {1'b0, bits_base} + 7'd8;
      end
      3'd2: begin
        acc_next = {acc_base[27:0], data_word[7:0], data_word[15:8]};
        bits_sum = {1'b0, bits_base} + 7'd16;
      end
      3'd3: begin
        acc_next = {acc_base[19:0], data_word[7:0], data_word[15:8], data_word[23:16]};
        bits_sum = {1'b0, bits_base} + 7'd24;
      end
      default: begin
        acc_next = {acc_base[11:0], data_word};
        bits_sum = {1'b0, bits_base} + 7'd32;
      end
    endcase
    bits_after = (bits_sum > {1'b0, ACC_BITS}) ? ACC_BITS : bits_sum[VBC_W-1:0];

    d = pixel_bits(cfg.depth13);
    d1 = VBC_W'(d);
    d2 = {d, 1'b0};
    d3 = d2 + d1;
    if (bits_after >= d3) begin
      pixels = 2'd3;
      used = d3;
    end else if (bits_after >= d2) begin
      pixels = 2'd2;
      used = d2;
    end else if (bits_after >= d1) begin
      pixels = 2'd1;
      used = d1;
    end else begin
      pixels = 2'd0;
      used = '0;
    end
    bits_next = bits_after - used;
  end

  assign in_ready = !full;
  assign accept = in_valid && in_ready;
  assign push = accept && ((pixels != 2'd0) || frame_start);
  assign push_entry = '{acc: acc_next, bits: bits_after, pixels: pixels, start: frame_start};

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
      bits <= '0;
    end else if (accept) begin
      acc <= acc_next;
      bits <= bits_next;
    end
  end

endmodule

### rtl/core/prpu_queue.sv
`timescale 1ns / 1ps

module prpu_queue #(
  parameter int unsigned DEPTH = prpu_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  prpu_pkg::entry_t  push_entry,
  output logic              full,
  input  logic              pop,
  output logic              head_valid,
  output prpu_pkg::entry_t  head
);
  import prpu_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  entry_t           mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full = (count == CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

endmodule

### rtl/core/prpu_back.sv
`timescale 1ns / 1ps

module prpu_back (
  input  logic                            clk,
  input  logic                            rst,
  input  prpu_pkg::cfg_t                  cfg,
  input  logic                            head_valid,
  input  prpu_pkg::entry_t                head,
  output logic                            pop,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [prpu_pkg::PIX_W-1:0]      pixel_value,
  output logic [prpu_pkg::POS_W-1:0]      pixel_row,
  output logic [prpu_pkg::POS_W-1:0]      pixel_column,
  output logic [prpu_pkg::ADDR_W-1:0]     pixel_address,
  output logic                            last_of_run,
  output logic                            frame_complete
);
  import prpu_pkg::*;

  typedef struct packed {
    logic [PIX_W-1:0]  value;
    logic [POS_W-1:0]  row;
    logic [POS_W-1:0]  col;
    logic [ADDR_W-1:0] product;
    logic              last;
    logic              done;
  } stage_t;

  logic [DIM_W-1:0]   row;
  logic [POS_W-1:0]   col;
  logic               finished;
  logic [1:0]         pix_idx;
  stage_t             s1;
  logic               s1_valid;

  logic               clear;
  logic               eff_fin;
  logic [DIM_W-1:0]   eff_row;
  logic [POS_W-1:0]   eff_col;
  logic [4:0]         d;
  logic [VBC_W-1:0]   offset;
  logic [VBC_W-1:0]   pos;
  logic [ACC_W-1:0]   shifted;
  logic [12:0]        pix;
  logic [PIX_W-1:0]   value;
  logic [DIM_W-1:0]   col_inc;
  logic [DIM_W-1:0]   row_inc;
  logic [2*DIM_W-1:0] product;
  logic               wrap;
  logic               done;
  logic               last_px;
  logic               skip;
  logic               stop;
  logic               emit;
  logic               s1_ready;
  logic               s2_load;

  always_comb begin
    clear = head.start && (pix_idx == 2'd0);
    eff_fin = clear ? 1'b0 : finished;
    eff_row = clear ? '0 : row;
    eff_col = clear ? '0 : col;

    d = pixel_bits(cfg.depth13);
    case (pix_idx)
      2'd0:    offset = VBC_W'(d);
      2'd1:    offset = {d, 1'b0};
      default: offset = {d, 1'b0} + VBC_W'(d);
    endcase
    pos = head.bits - offset;
    shifted = head.acc >> pos;
    pix = shifted[12:0] & (cfg.depth13 ? MASK_13 : MASK_12);
    value = cfg.depth13 ? {pix, 3'b000} : {pix[11:0], 4'b0000};

    col_inc = {1'b0, eff_col} + 1'b1;
    row_inc = eff_row + 1'b1;
    wrap = (col_inc >= cfg.width);
    done = wrap && (row_inc >= cfg.height);
    last_px = (pix_idx == head.pixels - 2'd1) || done;
    product = eff_row * cfg.stride;

    skip = (head.pixels == 2'd0) || eff_fin;
    stop = !skip && (eff_row >= cfg.height);
    s2_load = s1_valid && (!out_valid || out_ready);
    s1_ready = !s1_valid || s2_load;
    emit = head_valid && !skip && !stop && s1_ready;
    pop = head_valid && (skip || stop || (emit && last_px));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row <= '0;
      col <= '0;
      finished <= 1'b0;
      pix_idx <= '0;
      s1_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (head_valid && (skip || stop)) begin
        row <= eff_row;
        col <= eff_col;
        finished <= eff_fin || stop;
        pix_idx <= '0;
      end else if (emit) begin
        row <= wrap ? row_inc : eff_row;
        col <= wrap ? '0 : col_inc[POS_W-1:0];
        finished <= done;
        pix_idx <= last_px ? 2'd0 : pix_idx + 2'd1;
      end
      if (s1_ready) begin
        s1_valid <= emit;
      end
      if (s2_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && emit) begin
      s1 <= '{value: value, row: eff_row[POS_W-1:0], col: eff_col,
              product: product[ADDR_W-1:0], last: last_px, done: done};
    end
    if (s2_load) begin
      pixel_value <= s1.value;
      pixel_row <= s1.row;
      pixel_column <= s1.col;
      pixel_address <= s1.product + ADDR_W'(s1.col);
      last_of_run <= s1.last;
      frame_complete <= s1.done;
    end
  end

endmodule

### rtl/core/packed_raw_pixel_unpacker_core.sv
`timescale 1ns / 1ps

// Unpacks 12-bit or 13-bit raw pixels, MSB first, from packed 32-bit words and
// reports each one left-justified to 16 bits with its row, column and
// row * stride + column address. A word with byte_count of four is appended
// whole; one to three bytes are appended as a tail, first byte most
// significant. The front end takes one transaction per cycle while its entry
// queue has room, and the back end sends one pixel per cycle while out_ready
// does not stall its single extraction and output path. A transaction that
// only starts a frame yields no pixel. After it is accepted, the first pixel
// of a transaction passes through the entry queue, the address multiply
// register and the output register. Pixels past width times height are
// dropped until the next frame_start. Geometry and depth registers must be
// written only while the block is idle; the block itself does not enforce it.
module packed_raw_pixel_unpacker_core #(
  parameter int unsigned QUEUE_DEPTH = prpu_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [1:0]                      cfg_index,
  input  logic [prpu_pkg::DIM_W-1:0]      cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [31:0]                     data_word,
  input  logic [2:0]                      byte_count,
  input  logic                            frame_start,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [prpu_pkg::PIX_W-1:0]      pixel_value,
  output logic [prpu_pkg::POS_W-1:0]      pixel_row,
  output logic [prpu_pkg::POS_W-1:0]      pixel_column,
  output logic [prpu_pkg::ADDR_W-1:0]     pixel_address,
  output logic                            last_of_run,
  output logic                            frame_complete
);
  import prpu_pkg::*;

  cfg_t   cfg;
  logic   full;
  logic   push;
  entry_t push_entry;
  logic   pop;
  logic   head_valid;
  entry_t head;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{depth13: 1'b0, width: WIDTH_RESET, height: HEIGHT_RESET,
               stride: STRIDE_RESET};
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_BIT_DEPTH:    cfg.depth13 <= cfg_data[0];
        REG_FRAME_WIDTH:  cfg.width <= sat_dim(cfg_data);
        REG_FRAME_HEIGHT: cfg.height <= sat_dim(cfg_data);
        REG_LINE_STRIDE:  cfg.stride <= sat_dim(cfg_data);
        default: ;
      endcase
    end
  end

  prpu_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .data_word  (data_word),
    .byte_count (byte_count),
    .frame_start(frame_start),
    .full       (full),
    .push       (push),
    .push_entry (push_entry)
  );

  prpu_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_entry(push_entry),
    .full      (full),
    .pop       (pop),
    .head_valid(head_valid),
    .head      (head)
  );

  prpu_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .head_valid    (head_valid),
    .head          (head),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .pixel_value   (pixel_value),
    .pixel_row     (pixel_row),
    .pixel_column  (pixel_column),
    .pixel_address (pixel_address),
    .last_of_run   (last_of_run),
    .frame_complete(frame_complete)
  );

endmodule

### rtl/core/prpu_checker.sv
`timescale 1ns / 1ps

`include "packed_raw_pixel_unpacker_core_assert.svh"

module prpu_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [prpu_pkg::PIX_W-1:0]      pixel_value,
  input logic [prpu_pkg::ADDR_W-1:0]     pixel_address,
  input logic                            last_of_run,
  input logic                            frame_complete
);

  `PRPU_ASSERT(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(pixel_value))
  `PRPU_ASSERT(a_addr_stable, clk, rst, out_valid && !out_ready |=> $stable(pixel_address))
  `PRPU_ASSERT(a_complete_is_last, clk, rst, out_valid && frame_complete |-> last_of_run)
  `PRPU_ASSERT(a_value_justified, clk, rst, out_valid |-> pixel_value[2:0] == 3'b000)
  `PRPU_ASSERT_RESET(a_reset_idle, clk, rst |=> !out_valid && in_ready)

endmodule

bind packed_raw_pixel_unpacker_core prpu_checker u_prpu_checker (
  .clk           (clk),
  .rst           (rst),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .pixel_value   (pixel_value),
  .pixel_address (pixel_address),
  .last_of_run   (last_of_run),
  .frame_complete(frame_complete)
);
